### src/bdlr_pkg.sv
// ----------------------------------------------------------------------------
// bdlr_pkg
// Shared types and constants of the button debouncer with long press,
// auto repeat and UP+DOWN chord.
// ----------------------------------------------------------------------------
package bdlr_pkg;

  // Button count and derived event slot layout
  localparam int NUM_BUTTONS = 5;
  localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  // slot 0: chord, slot 1+2i: first event of button i, slot 2+2i: trailing release
  localparam int SLOTS       = 1 + 2 * NUM_BUTTONS;
  localparam int SLOT_IDX_W  = $clog2(SLOTS);

  // Field widths
  localparam int TICK_W   = 32;
  localparam int KEY_W    = 3;
  localparam int KIND_W   = 3;
  localparam int SEQ_W    = 32;
  localparam int SETTLE_W = 4;

  // Stream data widths, padded to whole bytes
  localparam int IN_BITS     = NUM_BUTTONS + TICK_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = KEY_W + KIND_W + SEQ_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd2;

  // Reset values of the registers
  localparam logic [TICK_W-1:0]   LONG_PRESS_RST = 32'd2000;
  localparam logic [TICK_W-1:0]   REPEAT_RST     = 32'd200;
  localparam logic [SETTLE_W-1:0] DEBOUNCE_RST   = 4'd3;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_UP    = 3'd0;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 3'd1;
  localparam logic [KEY_W-1:0] KEY_OK    = 3'd4;
  localparam logic [KEY_W-1:0] KEY_BACK  = 3'd5;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_PRESS   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SHORT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LONG    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REPEAT  = 3'd4;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Events of one poll, as classified by the front
  typedef struct packed {
    logic [SLOTS-1:0]                   mask;       // pending event slots
    logic                               chord_rel;  // chord slot is a release
    logic [NUM_BUTTONS-1:0][KIND_W-1:0] kinds;      // kind of each first slot
  } ev_rec_t;

endpackage

### src/bdlr_front.sv
// ----------------------------------------------------------------------------
// bdlr_front
// Takes one poll a cycle unless stalled, runs chord, debounce and hold timing
// on the stored state and hands the poll's events to the queue as a slot mask.
// ----------------------------------------------------------------------------
module bdlr_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bdlr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bdlr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 poll_valid,
  input  logic [bdlr_pkg::NUM_BUTTONS-1:0]     levels,
  input  logic [bdlr_pkg::TICK_W-1:0]          now,
  output logic                                 push,
  output bdlr_pkg::ev_rec_t                    push_rec
);

  localparam int NB = bdlr_pkg::NUM_BUTTONS;

  // Configuration registers
  logic [bdlr_pkg::TICK_W-1:0]   hold_limit;
  logic [bdlr_pkg::TICK_W-1:0]   rep_gap;
  logic [bdlr_pkg::SETTLE_W-1:0] debounce_polls;

  // Per-button state
  logic [NB-1:0]                 sampled, sampled_next;
  logic [NB-1:0]                 stable, stable_next;
  logic [NB-1:0]                 long_done, long_done_next;
  logic [bdlr_pkg::SETTLE_W-1:0] settle [NB];
  logic [bdlr_pkg::SETTLE_W-1:0] settle_next [NB];
  logic [bdlr_pkg::TICK_W-1:0]   press_t [NB];
  logic [bdlr_pkg::TICK_W-1:0]   press_t_next [NB];
  logic [bdlr_pkg::TICK_W-1:0]   rep_t [NB];
  logic [bdlr_pkg::TICK_W-1:0]   rep_t_next [NB];

  // Chord state
  logic                          chord_active, chord_active_next;
  logic                          chord_sent, chord_sent_next;
  logic [bdlr_pkg::TICK_W-1:0]   chord_start, chord_start_next;

  logic                          chord_now;
  logic                          down;
  logic [bdlr_pkg::TICK_W-1:0]   held, since_rep, chord_held;
  bdlr_pkg::ev_rec_t             rec;

  assign chord_now  = !levels[0] && !levels[1];
  assign chord_held = now - chord_start;

  // Classification of one poll
  always_comb begin
    rec               = '0;
    chord_active_next = chord_active;
    chord_sent_next   = chord_sent;
    chord_start_next  = chord_start;
    sampled_next      = sampled;
    stable_next       = stable;
    long_done_next    = long_done;
    down              = 1'b0;
    held              = '0;
    since_rep         = '0;
    for (int i = 0; i < NB; i++) begin
      settle_next[i]  = settle[i];
      press_t_next[i] = press_t[i];
      rep_t_next[i]   = rep_t[i];
    end

    // chord on raw UP and DOWN
    if (chord_now && !chord_active) begin
      chord_active_next = 1'b1;
      chord_start_next  = now;
      chord_sent_next   = 1'b0;
    end else if (!chord_now) begin
      if (chord_sent) begin
        rec.mask[0]   = 1'b1;
        rec.chord_rel = 1'b1;
      end
      chord_active_next = 1'b0;
      chord_sent_next   = 1'b0;
    end else if (!chord_sent && chord_held >= hold_limit) begin
      chord_sent_next = 1'b1;
      rec.mask[0]     = 1'b1;
    end

    // per-button debounce and hold timing
    for (int i = 0; i < NB; i++) begin
      down      = !levels[i];
      held      = now - press_t[i];
      since_rep = now - rep_t[i];
      if (down != sampled[i]) begin
        sampled_next[i] = down;
        settle_next[i]  = bdlr_pkg::SETTLE_W'(1);
      end else if (settle[i] < debounce_polls) begin
        settle_next[i] = settle[i] + bdlr_pkg::SETTLE_W'(1);
      end else if (stable[i] == down) begin
        if (down) begin
          if (!long_done[i] && held >= hold_limit) begin
            long_done_next[i] = 1'b1;
            rep_t_next[i]     = now;
            rec.mask[1+2*i]   = 1'b1;
            rec.kinds[i]      = bdlr_pkg::KIND_LONG;
          end else if (long_done[i] && since_rep >= rep_gap) begin
            rep_t_next[i] = now;
            if (bdlr_pkg::KEY_W'(i) != bdlr_pkg::KEY_OK) begin
              rec.mask[1+2*i] = 1'b1;
              rec.kinds[i]    = bdlr_pkg::KIND_REPEAT;
            end
          end
        end
      end else begin
        stable_next[i] = down;
        if (down) begin
          press_t_next[i]   = now;
          rep_t_next[i]     = now;
          long_done_next[i] = 1'b0;
          rec.mask[1+2*i]   = 1'b1;
          rec.kinds[i]      = bdlr_pkg::KIND_PRESS;
        end else if (!long_done[i]) begin
          rec.mask[1+2*i] = 1'b1;
          rec.mask[2+2*i] = 1'b1;
          rec.kinds[i]    = bdlr_pkg::KIND_SHORT;
        end else begin
          rec.mask[1+2*i] = 1'b1;
          rec.kinds[i]    = bdlr_pkg::KIND_RELEASE;
        end
      end
    end
  end

  // Only polls that raise events go to the queue
  assign push     = poll_valid && (rec.mask != '0);
  assign push_rec = rec;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_limit     <= bdlr_pkg::LONG_PRESS_RST;
      rep_gap        <= bdlr_pkg::REPEAT_RST;
      debounce_polls <= bdlr_pkg::DEBOUNCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdlr_pkg::REG_LONG_PRESS: hold_limit     <= cfg_data[bdlr_pkg::TICK_W-1:0];
        bdlr_pkg::REG_REPEAT:     rep_gap        <= cfg_data[bdlr_pkg::TICK_W-1:0];
        bdlr_pkg::REG_DEBOUNCE:   debounce_polls <= cfg_data[bdlr_pkg::SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // State update on each accepted poll
  always_ff @(posedge clk) begin
    if (rst) begin
      sampled      <= '0;
      stable       <= '0;
      long_done    <= '0;
      chord_active <= 1'b0;
      chord_sent   <= 1'b0;
      chord_start  <= '0;
      for (int i = 0; i < NB; i++) begin
        settle[i]  <= bdlr_pkg::DEBOUNCE_RST;
        press_t[i] <= '0;
        rep_t[i]   <= '0;
      end
    end else if (poll_valid) begin
      sampled      <= sampled_next;
      stable       <= stable_next;
      long_done    <= long_done_next;
      chord_active <= chord_active_next;
      chord_sent   <= chord_sent_next;
      chord_start  <= chord_start_next;
      for (int i = 0; i < NB; i++) begin
        settle[i]  <= settle_next[i];
        press_t[i] <= press_t_next[i];
        rep_t[i]   <= rep_t_next[i];
      end
    end
  end

endmodule

### src/bdlr_queue.sv
// ----------------------------------------------------------------------------
// bdlr_queue
// Short FIFO of per-poll event records between front and back.
// ----------------------------------------------------------------------------
module bdlr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bdlr_pkg::ev_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output bdlr_pkg::ev_rec_t pop_rec,
  output logic              empty
);

  bdlr_pkg::ev_rec_t             store [bdlr_pkg::QUEUE_DEPTH];
  logic [bdlr_pkg::QPTR_W-1:0]   wr_ptr;
  logic [bdlr_pkg::QPTR_W-1:0]   rd_ptr;
  logic [bdlr_pkg::QPTR_W:0]     count;
  logic                          do_push, do_pop;

  assign full    = (count == (bdlr_pkg::QPTR_W+1)'(bdlr_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_rec = store[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= push_rec;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + bdlr_pkg::QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + bdlr_pkg::QPTR_W'(1);
      if (do_push && !do_pop)      count <= count + (bdlr_pkg::QPTR_W+1)'(1);
      else if (do_pop && !do_push) count <= count - (bdlr_pkg::QPTR_W+1)'(1);
    end
  end

endmodule

### src/bdlr_back.sv
// ----------------------------------------------------------------------------
// bdlr_back
// Walks one poll's mask, lowest slot first, and unless stalled drives one
// event a cycle into the output register with the running sequence number.
// ----------------------------------------------------------------------------
module bdlr_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  input  bdlr_pkg::ev_rec_t                    q_rec,
  output logic                                 q_pop,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [bdlr_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                 m_tlast
);

  localparam int SW = bdlr_pkg::SLOT_IDX_W;

  bdlr_pkg::ev_rec_t             cur;
  logic [bdlr_pkg::SEQ_W-1:0]    seq;
  logic [SW-1:0]                 sel;
  logic [SW-1:0]                 sel_m1;
  logic [bdlr_pkg::BTN_IDX_W-1:0] btn;
  logic [bdlr_pkg::SLOTS-1:0]    rest;
  logic [bdlr_pkg::KEY_W-1:0]    key;
  logic [bdlr_pkg::KIND_W-1:0]   kind;
  logic                          found;
  logic                          adv;

  // Lowest pending slot
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int s = 0; s < bdlr_pkg::SLOTS; s++) begin
      if (cur.mask[s] && !found) begin
        found = 1'b1;
        sel   = SW'(s);
      end
    end
  end

  assign rest   = cur.mask & (cur.mask - bdlr_pkg::SLOTS'(1));
  assign sel_m1 = sel - SW'(1);
  assign btn    = bdlr_pkg::BTN_IDX_W'(sel_m1 >> 1);

  // Key and kind of the selected slot
  always_comb begin
    if (sel == '0) begin
      key  = bdlr_pkg::KEY_BACK;
      kind = cur.chord_rel ? bdlr_pkg::KIND_RELEASE : bdlr_pkg::KIND_PRESS;
    end else begin
      key  = bdlr_pkg::KEY_W'(btn);
      kind = sel[0] ? cur.kinds[btn] : bdlr_pkg::KIND_RELEASE;
    end
  end

  assign adv   = !m_tvalid || m_tready;
  assign q_pop = (cur.mask == '0) && !q_empty;

  // Current record
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.mask <= '0;
    end else if (q_pop) begin
      cur <= q_rec;
    end else if (adv && found) begin
      cur.mask <= rest;
    end
  end

  // Output register and sequence counter
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      seq      <= '0;
    end else if (adv) begin
      m_tvalid <= found;
      if (found) seq <= seq + bdlr_pkg::SEQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && found) begin
      m_tdata <= bdlr_pkg::OUT_TDATA_W'({seq + bdlr_pkg::SEQ_W'(1), kind, key});
      m_tlast <= (rest == '0);
    end
  end

endmodule

### src/button_debounce_long_repeat.sv
// ----------------------------------------------------------------------------
// button_debounce_long_repeat
// Five-button poller: debounce, long press, auto repeat and UP+DOWN chord
// as Back, with sequence-numbered event items.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | contents
//  s_*     | in        | tvalid/tready    | one poll: levels and tick
//  m_*     | out       | tvalid/tready    | one event: key, kind, sequence; tlast
//  cfg_*   | in        | cfg_we           | register index and write data
//
//  A poll is classified in the cycle it is accepted, so polls may follow
//  back to back while the queue (four polls deep) has room.
//  The back loads a poll's record from the queue, then emits one event per
//  cycle while the output is not stalled; a poll carries at most 11 events.
//  Reset is synchronous and sets the control state and registers; queue
//  storage and output data are not reset. The output register holds while
//  m_tvalid is high and m_tready is low; polls stall only on a full queue.
// ----------------------------------------------------------------------------
module button_debounce_long_repeat (
  input  logic                                 clk,
  input  logic                                 rst,
  // slave side
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [bdlr_pkg::IN_TDATA_W-1:0]      s_tdata,  // button_levels, tick_now
  // master side
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [bdlr_pkg::OUT_TDATA_W-1:0]     m_tdata,  // event_key, event_kind,
                                                         // event_sequence
  output logic                                 m_tlast,  // last_event
  // configuration
  input  logic                                 cfg_we,
  input  logic [bdlr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bdlr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic              q_full, q_empty, q_pop, push, poll_valid;
  bdlr_pkg::ev_rec_t push_rec, q_rec;

  assign s_tready   = !q_full;
  assign poll_valid = s_tvalid && s_tready;

  // Front: classify polls
  bdlr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .poll_valid (poll_valid),
    .levels     (s_tdata[bdlr_pkg::NUM_BUTTONS-1:0]),
    .now        (s_tdata[bdlr_pkg::IN_BITS-1:bdlr_pkg::NUM_BUTTONS]),
    .push       (push),
    .push_rec   (push_rec)
  );

  // Queue of per-poll records
  bdlr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .pop_rec  (q_rec),
    .empty    (q_empty)
  );

  // Back: serialise events
  bdlr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_rec    (q_rec),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
